[rtl/ipmi_response_checker_defines.svh]
// Assertion macros shared by the response checker RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef IPMI_RESPONSE_CHECKER_DEFINES_SVH
`define IPMI_RESPONSE_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define IRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irc check failed");

// Next-cycle implication, disabled while in reset
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irc check failed");

`else

`define IRC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/irc_pkg.sv]
// Types and constants for the IPMI response checker.
// No dependencies.
`default_nettype none

package irc_pkg;

    // packet kinds
    localparam logic [3:0] KIND_AUTHCAP_V20  = 4'd0;
    localparam logic [3:0] KIND_AUTHCAP      = 4'd1;
    localparam logic [3:0] KIND_CHALLENGE    = 4'd2;
    localparam logic [3:0] KIND_ACTIVATE     = 4'd3;
    localparam logic [3:0] KIND_PRIVILEGE    = 4'd4;
    localparam logic [3:0] KIND_CLOSE        = 4'd5;
    localparam logic [3:0] KIND_CIPHER       = 4'd6;
    localparam logic [3:0] KIND_CHASSIS_STAT = 4'd7;
    localparam logic [3:0] KIND_CHASSIS_CTRL = 4'd8;

    // bit positions in check_enable
    localparam int CHK_SEQ        = 0;
    localparam int CHK_SESSION    = 1;
    localparam int CHK_NETFN      = 2;
    localparam int CHK_RQSEQ      = 3;
    localparam int CHK_CMD        = 4;
    localparam int CHK_COMPLETION = 5;

    localparam logic [5:0] NETFN_CHASSIS_RSP = 6'h01;
    localparam logic [5:0] NETFN_APP_RSP     = 6'h07;
    localparam logic [7:0] CC_SUCCESS        = 8'h00;

    // 9-bit so that an unknown kind matches no command byte
    localparam logic [8:0] CMD_NONE = 9'h100;

    typedef struct packed {
        logic [3:0]  packet_kind;
        logic [31:0] session_seq;
        logic [31:0] session_ident;
        logic [31:0] granted_session;
        logic [5:0]  net_function;
        logic [5:0]  requester_seq;
        logic [5:0]  expected_requester_seq;
        logic [7:0]  command_code;
        logic [7:0]  completion_code;
        logic [5:0]  check_enable;
    } item_t;

    typedef struct packed {
        logic seq_ok;
        logic session_ok;
        logic netfn_ok;
        logic rqseq_ok;
        logic command_ok;
        logic completion_ok;
        logic packet_ok;
    } result_t;

    function automatic logic [8:0] kind_command(input logic [3:0] kind);
        logic [8:0] cmd;
        case (kind)
            KIND_AUTHCAP_V20:  cmd = 9'h038;
            KIND_AUTHCAP:      cmd = 9'h038;
            KIND_CHALLENGE:    cmd = 9'h039;
            KIND_ACTIVATE:     cmd = 9'h03A;
            KIND_PRIVILEGE:    cmd = 9'h03B;
            KIND_CLOSE:        cmd = 9'h03C;
            KIND_CIPHER:       cmd = 9'h054;
            KIND_CHASSIS_STAT: cmd = 9'h001;
            KIND_CHASSIS_CTRL: cmd = 9'h002;
            default:           cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

[rtl/irc_seq_window.sv]
// Anti-replay sliding window over the 32-bit session sequence number.
// Depends on irc_pkg and ipmi_response_checker_defines.svh.
`default_nettype none
`include "ipmi_response_checker_defines.svh"

module irc_seq_window #(
    parameter int WINDOW = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upd,
    input  logic        enable,
    input  logic [3:0]  kind,
    input  logic [31:0] seq,
    output logic        seq_pass
);

    localparam int SHW = $clog2(WINDOW + 1);

    typedef logic [WINDOW-1:0] bitmap_t;

    logic [31:0]    highest_reg;
    logic [31:0]    highest_next;
    bitmap_t        bitmap_reg;
    bitmap_t        bitmap_next;
    logic [31:0]    ahead;
    logic [31:0]    behind;
    logic [SHW-1:0] ahead_sh;
    logic [SHW-1:0] behind_sh;
    logic           in_ahead;
    logic           in_behind;
    logic           pre_session;
    bitmap_t        ahead_map;
    bitmap_t        behind_bit;
    logic           commit;

    assign commit = upd && enable;

    always_comb
    begin
        ahead       = seq - highest_reg;
        behind      = highest_reg - seq;
        ahead_sh    = ahead[SHW-1:0];
        behind_sh   = SHW'(behind[SHW-1:0] - 1'b1);
        in_ahead    = (ahead <= 32'(WINDOW));
        in_behind   = (behind <= 32'(WINDOW));
        // bit k of the map marks the number k+1 below the highest
        ahead_map   = (bitmap_reg << ahead_sh) | (bitmap_t'(1) << SHW'(ahead_sh - 1'b1));
        behind_bit  = bitmap_t'(1) << behind_sh;
        pre_session = kind inside {irc_pkg::KIND_AUTHCAP_V20, irc_pkg::KIND_AUTHCAP,
                                   irc_pkg::KIND_CHALLENGE, irc_pkg::KIND_CIPHER};

        seq_pass     = 1'b0;
        highest_next = highest_reg;
        bitmap_next  = bitmap_reg;
        if (pre_session)
        begin
            seq_pass = 1'b1;
        end
        else if (kind == irc_pkg::KIND_ACTIVATE)
        begin
            seq_pass     = 1'b1;
            highest_next = seq;
        end
        else if (seq == highest_reg)
        begin
            seq_pass = 1'b0;
        end
        else if (in_ahead)
        begin
            seq_pass     = 1'b1;
            bitmap_next  = ahead_map;
            highest_next = seq;
        end
        else if (in_behind)
        begin
            if ((bitmap_reg & behind_bit) == '0)
            begin
                seq_pass    = 1'b1;
                bitmap_next = bitmap_reg | behind_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg <= '0;
            bitmap_reg  <= '0;
        end
        else if (commit)
        begin
            highest_reg <= highest_next;
            bitmap_reg  <= bitmap_next;
        end
    end

    `IRC_ASSERT_NEXT(a_window_held, clk, rst_n, !commit,
                     $stable(highest_reg) && $stable(bitmap_reg))
    `IRC_ASSERT_SAME(a_duplicate_rejected, clk, rst_n,
                     !pre_session && kind != irc_pkg::KIND_ACTIVATE && seq == highest_reg,
                     !seq_pass)

endmodule

`default_nettype wire

[rtl/irc_field_check.sv]
// Session id, netfn, rq sequence, command and completion checks; holds the
// active session id. Depends on irc_pkg.
`default_nettype none

module irc_field_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd,
    input  logic              accept_zero_session,
    input  irc_pkg::item_t    item,
    input  logic              seq_pass,
    output irc_pkg::result_t  result
);

    logic [31:0] active_session_reg;
    logic        no_session_kind;
    logic [5:0]  exp_netfn;
    logic [5:0]  en;

    assign en = item.check_enable;

    always_comb
    begin
        no_session_kind = item.packet_kind inside {irc_pkg::KIND_AUTHCAP_V20,
                                                   irc_pkg::KIND_AUTHCAP,
                                                   irc_pkg::KIND_CHALLENGE,
                                                   irc_pkg::KIND_ACTIVATE,
                                                   irc_pkg::KIND_CIPHER};
        exp_netfn = (item.packet_kind == irc_pkg::KIND_CHASSIS_STAT ||
                     item.packet_kind == irc_pkg::KIND_CHASSIS_CTRL)
                    ? irc_pkg::NETFN_CHASSIS_RSP : irc_pkg::NETFN_APP_RSP;

        result.seq_ok        = !en[irc_pkg::CHK_SEQ] || seq_pass;
        result.session_ok    = !en[irc_pkg::CHK_SESSION] || no_session_kind ||
                               (accept_zero_session && item.session_ident == '0) ||
                               (item.session_ident == active_session_reg);
        result.netfn_ok      = !en[irc_pkg::CHK_NETFN] || (item.net_function == exp_netfn);
        result.rqseq_ok      = !en[irc_pkg::CHK_RQSEQ] ||
                               (item.requester_seq == item.expected_requester_seq);
        result.command_ok    = !en[irc_pkg::CHK_CMD] ||
                               ({1'b0, item.command_code} ==
                                irc_pkg::kind_command(item.packet_kind));
        result.completion_ok = !en[irc_pkg::CHK_COMPLETION] ||
                               (item.completion_code == irc_pkg::CC_SUCCESS);
        result.packet_ok     = result.seq_ok && result.session_ok && result.netfn_ok &&
                               result.rqseq_ok && result.command_ok && result.completion_ok;
    end

    // activate response captures the granted id whatever the enables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_session_reg <= '0;
        end
        else if (upd && item.packet_kind == irc_pkg::KIND_ACTIVATE)
        begin
            active_session_reg <= item.granted_session;
        end
    end

endmodule

`default_nettype wire

[rtl/ipmi_response_checker.sv]
// IPMI LAN response header checker: an input register, then a result register.
// Throughput: one word per cycle while out_ready lets the result register
// advance; window state updates as a CHK_SEQ-enabled word moves into it.
// Reset clears the sequence window, active session, config and all valid flags.
// Depends on irc_pkg, irc_seq_window, irc_field_check and the defines header.
`default_nettype none
`include "ipmi_response_checker_defines.svh"

module ipmi_response_checker #(
    parameter int WINDOW = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  packet_kind,
    input  logic [31:0] session_seq,
    input  logic [31:0] session_ident,
    input  logic [31:0] granted_session,
    input  logic [5:0]  net_function,
    input  logic [5:0]  requester_seq,
    input  logic [5:0]  expected_requester_seq,
    input  logic [7:0]  command_code,
    input  logic [7:0]  completion_code,
    input  logic [5:0]  check_enable,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        seq_ok,
    output logic        session_ok,
    output logic        netfn_ok,
    output logic        rqseq_ok,
    output logic        command_ok,
    output logic        completion_ok,
    output logic        packet_ok
);

    logic              accept_zero_session_reg;
    logic              s1_valid_reg;
    irc_pkg::item_t    s1_item_reg;
    logic              out_valid_reg;
    irc_pkg::result_t  out_result_reg;
    irc_pkg::result_t  result;
    logic              advance;
    logic              s1_move;
    logic              seq_pass;

    assign cfg_ready = 1'b1;

    // result register free, or being emptied this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_zero_session_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            accept_zero_session_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.packet_kind            <= packet_kind;
            s1_item_reg.session_seq            <= session_seq;
            s1_item_reg.session_ident          <= session_ident;
            s1_item_reg.granted_session        <= granted_session;
            s1_item_reg.net_function           <= net_function;
            s1_item_reg.requester_seq          <= requester_seq;
            s1_item_reg.expected_requester_seq <= expected_requester_seq;
            s1_item_reg.command_code           <= command_code;
            s1_item_reg.completion_code        <= completion_code;
            s1_item_reg.check_enable           <= check_enable;
        end
        if (s1_move)
        begin
            out_result_reg <= result;
        end
    end

    irc_seq_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (s1_move),
        .enable   (s1_item_reg.check_enable[irc_pkg::CHK_SEQ]),
        .kind     (s1_item_reg.packet_kind),
        .seq      (s1_item_reg.session_seq),
        .seq_pass (seq_pass)
    );

    irc_field_check u_fields (
        .clk                 (clk),
        .rst_n               (rst_n),
        .upd                 (s1_move),
        .accept_zero_session (accept_zero_session_reg),
        .item                (s1_item_reg),
        .seq_pass            (seq_pass),
        .result              (result)
    );

    assign out_valid     = out_valid_reg;
    assign seq_ok        = out_result_reg.seq_ok;
    assign session_ok    = out_result_reg.session_ok;
    assign netfn_ok      = out_result_reg.netfn_ok;
    assign rqseq_ok      = out_result_reg.rqseq_ok;
    assign command_ok    = out_result_reg.command_ok;
    assign completion_ok = out_result_reg.completion_ok;
    assign packet_ok     = out_result_reg.packet_ok;

    `IRC_ASSERT_SAME(a_full_pipe_blocks, clk, rst_n,
                     s1_valid_reg && out_valid_reg && !out_ready, !in_ready)
    `IRC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && in_ready, s1_valid_reg)
    `IRC_ASSERT_SAME(a_packet_ok_summary, clk, rst_n, out_valid_reg,
                     packet_ok == (seq_ok && session_ok && netfn_ok && rqseq_ok &&
                                   command_ok && completion_ok))

endmodule

`default_nettype wire
